/* hw/rtl/tcw_pkg.sv */
// shared constants, types and helpers of the text console writer
package tcw_pkg;

    // geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int POS_W  = $clog2(CELLS + 1);

    // item and cell field widths
    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CURPOS_W = 11;
    localparam int CELL_W   = 2 * BYTE_W;

    // command queue depth
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // character codes
    localparam logic [BYTE_W-1:0] CH_BS       = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL       = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_THREE    = 8'h33;
    localparam logic [BYTE_W-1:0] CH_FOUR     = 8'h34;
    localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_M        = 8'h6D;

    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [BYTE_W-1:0] ATTR_FG_KEEP = 8'h0F;
    localparam logic [BYTE_W-1:0] ATTR_BG_KEEP = 8'hF0;

    typedef enum logic [1:0] {
        OP_PUT,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } cmd_op_t;

    typedef enum logic [1:0] {
        K_PRINT,
        K_NEWLINE,
        K_BACKSPACE,
        K_IGNORE
    } byte_kind_t;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_BRACKET,
        ESC_SELECT,
        ESC_DIGIT
    } esc_phase_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_EXEC,
        BK_PRIME,
        BK_SCROLL,
        BK_CLEAR,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        cmd_op_t            op;
        byte_kind_t         kind;
        logic [BYTE_W-1:0]  char_byte;
        logic [INDEX_W-1:0] cell_index;
        logic [BYTE_W-1:0]  attr;
    } cmd_t;

    function automatic byte_kind_t byte_kind(input logic [BYTE_W-1:0] b);
        byte_kind_t k;
        unique case (b) inside
            CH_NL:         k = K_NEWLINE;
            CH_TAB, CH_CR: k = K_IGNORE;
            CH_BS:         k = K_BACKSPACE;
            default:       k = K_PRINT;
        endcase
        return k;
    endfunction

    function automatic logic [POS_W-1:0] cell_pos(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        return POS_W'(row) * POS_W'(COLUMNS) + POS_W'(col);
    endfunction

endpackage

/* hw/rtl/tcw_item_if.sv */
// input channel of the text console writer
interface tcw_item_if
    import tcw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   char_byte;
    logic [INDEX_W-1:0]  cell_index;

    modport source (output valid, action, char_byte, cell_index, input ready);
    modport sink   (input valid, action, char_byte, cell_index, output ready);
endinterface

/* hw/rtl/tcw_result_if.sv */
// result channel of the text console writer
interface tcw_result_if
    import tcw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CURPOS_W-1:0] cursor_position;
    logic [BYTE_W-1:0]   read_char;
    logic [BYTE_W-1:0]   read_attr;
    logic [BYTE_W-1:0]   current_attr;

    modport source (output valid, cursor_position, read_char, read_attr, current_attr,
                    input ready);
    modport sink   (input valid, cursor_position, read_char, read_attr, current_attr,
                    output ready);
endinterface

/* hw/rtl/tcw_ram.sv */
// generic single-write, single-read ram with registered read data
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/tcw_front.sv */
// front end: accepts beats, runs the color escape decoder, emits commands
module tcw_front
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tcw_item_if.sink    item,
    input  logic        init_done,
    input  logic        cmdq_full,
    output logic        cmdq_push,
    output cmd_t        cmdq_data
);
    esc_phase_t        phase_reg, phase_next;
    logic [BYTE_W-1:0] attr_reg, attr_next;
    logic              bg_reg, bg_next;
    logic              accept;
    logic [BYTE_W-1:0] digit_diff;
    logic [3:0]        nibble;

    assign item.ready = init_done && !cmdq_full;
    assign accept     = item.valid && item.ready;

    assign digit_diff = item.char_byte - CH_ZERO;
    assign nibble     = (item.char_byte >= CH_ZERO && item.char_byte <= CH_NINE)
                        ? digit_diff[3:0] : 4'd0;

    // escape phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (item.action)
                ACT_PUT:
                begin
                    unique case (phase_reg)
                        ESC_IDLE:
                            phase_next = (item.char_byte == CH_LBRACKET) ? ESC_BRACKET
                                                                         : ESC_IDLE;
                        ESC_BRACKET:
                            phase_next = (item.char_byte == CH_THREE ||
                                          item.char_byte == CH_FOUR) ? ESC_SELECT
                                                                     : ESC_IDLE;
                        ESC_SELECT:
                            phase_next = ESC_DIGIT;
                        ESC_DIGIT:
                            phase_next = ESC_IDLE;
                        default:
                            phase_next = ESC_IDLE;
                    endcase
                end
                ACT_CLEAR: phase_next = ESC_IDLE;
                default:   phase_next = phase_reg;
            endcase
        end
    end

    // command, attribute and selector
    always_comb
    begin
        attr_next            = attr_reg;
        bg_next              = bg_reg;
        cmdq_push            = accept;
        cmdq_data.op         = OP_NOP;
        cmdq_data.kind       = byte_kind(item.char_byte);
        cmdq_data.char_byte  = item.char_byte;
        cmdq_data.cell_index = item.cell_index;
        unique case (item.action)
            ACT_PUT:
            begin
                unique case (phase_reg)
                    ESC_IDLE:
                        cmdq_data.op = (item.char_byte == CH_LBRACKET) ? OP_NOP : OP_PUT;
                    ESC_BRACKET:
                    begin
                        if (item.char_byte == CH_THREE || item.char_byte == CH_FOUR)
                        begin
                            cmdq_data.op = OP_NOP;
                            if (accept)
                            begin
                                bg_next = (item.char_byte == CH_FOUR);
                            end
                        end
                        else
                        begin
                            cmdq_data.op = OP_PUT;
                        end
                    end
                    ESC_SELECT:
                    begin
                        cmdq_data.op = OP_NOP;
                        if (accept)
                        begin
                            attr_next = bg_reg ? ((attr_reg & ATTR_FG_KEEP) | {nibble, 4'd0})
                                               : ((attr_reg & ATTR_BG_KEEP) | {4'd0, nibble});
                        end
                    end
                    ESC_DIGIT:
                        cmdq_data.op = (item.char_byte == CH_M) ? OP_NOP : OP_PUT;
                    default:
                        cmdq_data.op = OP_NOP;
                endcase
            end
            ACT_CLEAR: cmdq_data.op = OP_CLEAR;
            ACT_READ:  cmdq_data.op = OP_READ;
            default:   cmdq_data.op = OP_NOP;
        endcase
        // result reports the attribute as it stands after this beat
        cmdq_data.attr = attr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ESC_IDLE;
            attr_reg  <= ATTR_RESET;
            bg_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            attr_reg  <= attr_next;
            bg_reg    <= bg_next;
        end
    end
endmodule

/* hw/rtl/tcw_cmd_fifo.sv */
// short command queue between front and back end
module tcw_cmd_fifo
    import tcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);
    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("command pushed into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("command popped from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
                     count_reg <= CMDQ_CNT_W'(CMDQ_DEPTH))
        else $error("queue count beyond depth");
endmodule

/* hw/rtl/tcw_back.sv */
// back end: cursor, cell store sweeps and result register
module tcw_back
    import tcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmdq_empty,
    input  cmd_t               cmdq_data,
    output logic               cmdq_pop,
    output logic               init_done,
    output logic               ram_we,
    output logic [ADDR_W-1:0]  ram_waddr,
    output logic [CELL_W-1:0]  ram_wdata,
    output logic [ADDR_W-1:0]  ram_raddr,
    input  logic [CELL_W-1:0]  ram_rdata,
    tcw_result_if.source       result
);
    back_state_t        state_reg, state_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    cmd_t               cmd_reg, cmd_next;
    logic               out_valid_reg;
    logic [CURPOS_W-1:0] pos_out_reg;
    logic [BYTE_W-1:0]  rchar_reg, rattr_reg, cattr_reg;

    logic               out_free;
    logic               cnt_last;
    logic               scroll_pending;
    logic               index_ok;
    logic [ADDR_W+INDEX_W-1:0] index_ext;
    logic [ADDR_W-1:0]  index_addr;
    logic [POS_W-1:0]   cur_pos;
    logic [POS_W+CURPOS_W-1:0] pos_ext;
    logic [ADDR_W:0]    scroll_src;

    assign out_free       = !out_valid_reg || result.ready;
    assign cnt_last       = (cnt_reg == ADDR_W'(CELLS - 1));
    assign scroll_pending = (row_reg == ROW_W'(ROWS));
    assign index_ok       = (int'(cmd_reg.cell_index) < CELLS);
    assign index_ext      = {{ADDR_W{1'b0}}, cmd_reg.cell_index};
    assign index_addr     = index_ok ? index_ext[ADDR_W-1:0] : '0;
    assign cur_pos        = cell_pos(row_reg, col_reg);
    assign pos_ext        = {{CURPOS_W{1'b0}}, cur_pos};
    assign scroll_src     = {1'b0, cnt_reg} + (ADDR_W+1)'(COLUMNS + 1);
    assign init_done      = (state_reg != BK_INIT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_INIT:   state_next = cnt_last ? BK_IDLE : BK_INIT;
            BK_IDLE:   state_next = (!cmdq_empty && out_free) ? BK_EXEC : BK_IDLE;
            BK_EXEC:
            begin
                unique case (cmd_reg.op)
                    OP_PUT:   state_next = scroll_pending ? BK_PRIME : BK_DONE;
                    OP_CLEAR: state_next = BK_CLEAR;
                    default:  state_next = BK_DONE;
                endcase
            end
            BK_PRIME:  state_next = BK_SCROLL;
            BK_SCROLL: state_next = cnt_last ? BK_EXEC : BK_SCROLL;
            BK_CLEAR:  state_next = cnt_last ? BK_DONE : BK_CLEAR;
            BK_DONE:   state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // datapath and store access
    always_comb
    begin
        cnt_next  = cnt_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        cmd_next  = cmd_reg;
        cmdq_pop  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = '0;
        ram_raddr = '0;
        unique case (state_reg)
            BK_INIT:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
            end
            BK_IDLE:
            begin
                if (!cmdq_empty && out_free)
                begin
                    cmdq_pop = 1'b1;
                    cmd_next = cmdq_data;
                end
            end
            BK_EXEC:
            begin
                cnt_next = '0;
                unique case (cmd_reg.op)
                    OP_PUT:
                    begin
                        if (!scroll_pending)
                        begin
                            case (cmd_reg.kind)
                                K_NEWLINE:
                                begin
                                    row_next = row_reg + 1'b1;
                                    col_next = '0;
                                end
                                K_BACKSPACE:
                                begin
                                    if (col_reg != '0)
                                    begin
                                        col_next = col_reg - 1'b1;
                                    end
                                    else if (row_reg != '0)
                                    begin
                                        row_next = row_reg - 1'b1;
                                        col_next = COL_W'(COLUMNS - 1);
                                    end
                                end
                                K_PRINT:
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = cur_pos[ADDR_W-1:0];
                                    ram_wdata = {cmd_reg.attr, cmd_reg.char_byte};
                                    if (col_reg == COL_W'(COLUMNS - 1))
                                    begin
                                        row_next = row_reg + 1'b1;
                                        col_next = '0;
                                    end
                                    else
                                    begin
                                        col_next = col_reg + 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    OP_READ: ram_raddr = index_addr;
                    default: ;
                endcase
            end
            BK_PRIME:
                ram_raddr = ADDR_W'(COLUMNS);
            BK_SCROLL:
            begin
                // copy one row up from the registered read data; last row gets zero cells
                ram_we    = 1'b1;
                ram_wdata = (cnt_reg < ADDR_W'(CELLS - COLUMNS)) ? ram_rdata : '0;
                ram_raddr = (scroll_src < (ADDR_W+1)'(CELLS)) ? scroll_src[ADDR_W-1:0] : '0;
                cnt_next  = cnt_last ? '0 : cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    row_next = ROW_W'(ROWS - 1);
                    col_next = '0;
                end
            end
            BK_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = {cmd_reg.attr, CH_SPACE};
                cnt_next  = cnt_last ? '0 : cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    row_next = '0;
                    col_next = '0;
                end
            end
            BK_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_INIT;
            cnt_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (state_reg == BK_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (state_reg == BK_DONE)
        begin
            pos_out_reg <= pos_ext[CURPOS_W-1:0];
            cattr_reg   <= cmd_reg.attr;
            if (cmd_reg.op == OP_READ && index_ok)
            begin
                rchar_reg <= ram_rdata[BYTE_W-1:0];
                rattr_reg <= ram_rdata[CELL_W-1:BYTE_W];
            end
            else
            begin
                rchar_reg <= '0;
                rattr_reg <= '0;
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.cursor_position = pos_out_reg;
    assign result.read_char       = rchar_reg;
    assign result.read_attr       = rattr_reg;
    assign result.current_attr    = cattr_reg;

    assert property (@(posedge clk) disable iff (!rst_n) row_reg <= ROW_W'(ROWS))
        else $error("cursor row beyond last row");
    assert property (@(posedge clk) disable iff (!rst_n) col_reg < COL_W'(COLUMNS))
        else $error("cursor column beyond last column");
    assert property (@(posedge clk) disable iff (!rst_n)
                     state_reg == BK_DONE |-> !out_valid_reg)
        else $error("result overwritten before taken");
    assert property (@(posedge clk) disable iff (!rst_n)
                     state_reg == BK_SCROLL && cnt_last |=> state_reg == BK_EXEC && row_reg ==
                     ROW_W'(ROWS - 1))
        else $error("scroll did not hand back to put");
endmodule

/* hw/rtl/text_console_writer.sv */
// top level of the text console writer: front end, command queue, back end, cell store
// results: a put, a read or a consumed escape byte each give a result beat; a put that
//   scrolls first sweeps the cell store to move every row up, and a clear first sweeps
//   it with spaces in the current attribute; the sweeps are one cell per cycle
// queueing: the back end sequencer sets the pace; two commands queue
// reset: rst_n is asynchronous, active low; afterwards the cell store is zeroed by a
//   clearing pass over all ROWS*COLUMNS cells during which no beat is accepted
module text_console_writer
    import tcw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tcw_item_if.sink      item,
    tcw_result_if.source  result
);
    // front to queue
    logic              cmdq_push;
    cmd_t              cmdq_push_data;
    logic              cmdq_full;
    // queue to back
    logic              cmdq_pop;
    cmd_t              cmdq_pop_data;
    logic              cmdq_empty;
    // back end status, low during the clearing pass after reset
    logic              init_done;
    // cell store port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // escape decoding and attribute tracking happen here, in beat order
    tcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .init_done (init_done),
        .cmdq_full (cmdq_full),
        .cmdq_push (cmdq_push),
        .cmdq_data (cmdq_push_data)
    );

    // decouples acceptance from long sweeps in the back end
    tcw_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmdq_push),
        .push_data (cmdq_push_data),
        .full      (cmdq_full),
        .pop       (cmdq_pop),
        .pop_data  (cmdq_pop_data),
        .empty     (cmdq_empty)
    );

    // cursor, scroll and clear sweeps, result register
    tcw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmdq_empty (cmdq_empty),
        .cmdq_data  (cmdq_pop_data),
        .cmdq_pop   (cmdq_pop),
        .init_done  (init_done),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .result     (result)
    );

    // character in the low byte, attribute in the high byte
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule
